@@ rtl/core/ppm_window_mass_search_unit_defines.svh @@
// ----------------------------------------------------------------------------
// ppm_window_mass_search_unit_defines.svh
// Assertion macros shared by the ppm window mass search unit.
// ----------------------------------------------------------------------------
`ifndef PPM_WINDOW_MASS_SEARCH_UNIT_DEFINES_SVH
`define PPM_WINDOW_MASS_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define PPM_WMS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ppm_wms: assertion failed");
// condition must never be seen outside reset
`define PPM_WMS_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ppm_wms: forbidden condition seen");
`else
`define PPM_WMS_ASSERT(lbl, clk, rst, prop)
`define PPM_WMS_NEVER(lbl, clk, rst, cond)
`endif

`endif

@@ rtl/core/ppm_wms_pkg.sv @@
// ----------------------------------------------------------------------------
// ppm_wms_pkg
// Widths, codes and shared types of the ppm window mass search unit.
// ----------------------------------------------------------------------------
package ppm_wms_pkg;

  // field widths
  localparam int MASS_W     = 30;
  localparam int CHARGE_W   = 4;
  localparam int TIME_W     = 16;
  localparam int INDEX_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int TOL_W      = 15;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 1;

  // parameter defaults
  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_MAX_MATCHES = 64;
  localparam int DEF_TIME_MARGIN = 128;

  localparam int TOL_RESET = 2560;

  // 256000000 = 15625 << 14: scale the mass difference by 15625 and
  // compare against the limit shifted down by 14 (exact, product is integer)
  localparam int PPM_MULT   = 15625;
  localparam int PPM_MULT_W = 14;
  localparam int PPM_SHIFT  = 14;
  localparam int PROD_W     = MASS_W + PPM_MULT_W;
  localparam int LIM_W      = MASS_W + TOL_W;
  localparam int LIMH_W     = LIM_W - PPM_SHIFT;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT = 1'b0,
    REG_TOLERANCE   = 1'b1
  } reg_idx_t;

  // one table word
  typedef struct packed {
    logic [MASS_W-1:0]   mass;
    logic [CHARGE_W-1:0] charge;
    logic [TIME_W-1:0]   rtime;
  } entry_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic [TOL_W-1:0]   tolerance;
  } cfg_t;

  // mass window position of the probed entry
  typedef struct packed {
    logic below;
    logic above;
  } win_flags_t;

endpackage

@@ rtl/core/ppm_wms_table.sv @@
// ----------------------------------------------------------------------------
// ppm_wms_table
// Feature table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ppm_wms_table import ppm_wms_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/ppm_wms_window.sv @@
// ----------------------------------------------------------------------------
// ppm_wms_window
// Mass window test: registered |m - q| * 15625, then compare to the limit.
// ----------------------------------------------------------------------------
module ppm_wms_window import ppm_wms_pkg::*; (
  input  logic              clk,
  input  logic              load,
  input  logic [MASS_W-1:0] mass,
  input  logic [MASS_W-1:0] query_mass,
  input  logic [LIMH_W-1:0] lim_hi,
  output win_flags_t        flags
);

  logic              lt;
  logic              gt;
  logic [MASS_W-1:0] diff;
  logic [PROD_W-1:0] prod;
  logic              over_lim;

  // absolute difference
  always_comb begin
    diff = (mass < query_mass) ? (query_mass - mass) : (mass - query_mass);
  end

  // scale stage
  always_ff @(posedge clk) begin
    if (load) begin
      lt   <= mass < query_mass;
      gt   <= mass > query_mass;
      prod <= PROD_W'(diff) * PROD_W'(PPM_MULT);
    end
  end

  // compare stage
  always_comb begin
    over_lim    = prod > PROD_W'(lim_hi);
    flags.below = lt && over_lim;
    flags.above = gt && over_lim;
  end

endmodule

@@ rtl/core/ppm_wms_seq.sv @@
// ----------------------------------------------------------------------------
// ppm_wms_seq
// Query sequencer: binary search for the window start, walk of the run,
// one-deep hold of the latest match so the final word carries last.
// ----------------------------------------------------------------------------
`include "ppm_window_mass_search_unit_defines.svh"

module ppm_wms_seq import ppm_wms_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int MAX_MATCHES = DEF_MAX_MATCHES,
  parameter int TIME_MARGIN = DEF_TIME_MARGIN,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [0:0]          op,
  input  logic [MASS_W-1:0]   query_mass,
  input  logic [CHARGE_W-1:0] query_charge,
  input  logic [TIME_W-1:0]   window_start,
  input  logic [TIME_W-1:0]   window_end,
  input  cfg_t                cfg,
  output logic                busy,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  entry_t              rd_data,
  output logic                win_load,
  output logic [MASS_W-1:0]   q_mass,
  output logic [LIMH_W-1:0]   lim_hi,
  input  win_flags_t          flags,
  output logic                result_strobe,
  output logic                hit,
  output logic [INDEX_W-1:0]  match_index,
  output logic                truncated,
  output logic                last
);

  localparam int NW   = AW + 1;
  localparam int XW   = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int CNTW = $clog2(MAX_MATCHES + 1);
  localparam int TW1  = TIME_W + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_SMUL   = 7'b0000100,
    S_SCMP   = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_WMUL   = 7'b0100000,
    S_WCMP   = 7'b1000000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [NW-1:0]       lo;
  logic [NW-1:0]       hi;
  logic [NW-1:0]       j;
  logic [NW:0]         mid_sum;
  logic [NW-1:0]       mid;
  logic [NW-1:0]       n_lim;
  logic [CHARGE_W-1:0] q_charge;
  logic [TIME_W-1:0]   ws;
  logic [TIME_W-1:0]   we;
  logic [LIM_W-1:0]    lim_full;
  logic                pend_valid;
  logic [INDEX_W-1:0]  pend_idx;
  logic [CNTW-1:0]     found;
  logic                accept;
  logic                search_open;
  logic                walk_open;
  logic                is_match;
  logic                full;
  logic                emit;
  logic                emit_hit;
  logic [INDEX_W-1:0]  emit_idx;
  logic                emit_trunc;
  logic                emit_last;

  // handshake and bounds
  always_comb begin
    busy        = (state != S_IDLE);
    accept      = start && !busy;
    n_lim       = (XW'(cfg.entry_count) > XW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                            : NW'(cfg.entry_count);
    mid_sum     = {1'b0, lo} + {1'b0, hi};
    mid         = NW'(mid_sum >> 1);
    search_open = lo < hi;
    walk_open   = j < n_lim;
    lim_full    = LIM_W'(query_mass) * LIM_W'(cfg.tolerance);
    full        = pend_valid && (found == CNTW'(MAX_MATCHES));
  end

  // charge and widened time window of the entry read back
  always_comb begin
    is_match = (rd_data.charge == q_charge) &&
               ((TW1'(rd_data.rtime) + TW1'(TIME_MARGIN)) > TW1'(ws)) &&
               (TW1'(rd_data.rtime) < (TW1'(we) + TW1'(TIME_MARGIN)));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept && (op == OP_QUERY)) state_next = S_SEARCH;
      S_SEARCH: state_next = search_open ? S_SMUL : S_WALK;
      S_SMUL:   state_next = S_SCMP;
      S_SCMP:   state_next = S_SEARCH;
      S_WALK:   state_next = walk_open ? S_WMUL : S_IDLE;
      S_WMUL:   state_next = S_WCMP;
      S_WCMP: begin
        if (flags.above || (is_match && full)) state_next = S_IDLE;
        else state_next = S_WALK;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // memory read and window stage control
  always_comb begin
    rd_en    = ((state == S_SEARCH) && search_open) || ((state == S_WALK) && walk_open);
    rd_addr  = (state == S_SEARCH) ? AW'(mid) : AW'(j);
    win_load = (state == S_SMUL) || (state == S_WMUL);
  end

  // result word selection: held match goes out when the next one shows up
  // or when the walk ends
  always_comb begin
    emit       = 1'b0;
    emit_hit   = pend_valid;
    emit_idx   = pend_valid ? pend_idx : '0;
    emit_trunc = 1'b0;
    emit_last  = 1'b1;
    if ((state == S_WALK) && !walk_open) begin
      emit = 1'b1;
    end else if ((state == S_WCMP) && flags.above) begin
      emit = 1'b1;
    end else if ((state == S_WCMP) && is_match && pend_valid) begin
      emit       = 1'b1;
      emit_hit   = 1'b1;
      emit_idx   = pend_idx;
      emit_trunc = full;
      emit_last  = full;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= emit;
      if (accept && (op == OP_QUERY)) begin
        pend_valid <= 1'b0;
      end else if ((state == S_WCMP) && !flags.above && is_match && !full) begin
        pend_valid <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept && (op == OP_QUERY)) begin
          q_mass   <= query_mass;
          q_charge <= query_charge;
          ws       <= window_start;
          we       <= window_end;
          lim_hi   <= LIMH_W'(lim_full >> PPM_SHIFT);
          lo       <= '0;
          hi       <= n_lim;
          found    <= '0;
        end
      end
      S_SEARCH: if (!search_open) j <= lo;
      S_SCMP: begin
        if (flags.below) lo <= NW'(mid + 1'b1);
        else hi <= mid;
      end
      S_WCMP: begin
        if (!flags.above) begin
          j <= NW'(j + 1'b1);
          if (is_match && !full) begin
            pend_idx <= INDEX_W'(j);
            found    <= CNTW'(found + 1'b1);
          end
        end
      end
      default: ;
    endcase
  end

  // output word
  always_ff @(posedge clk) begin
    if (emit) begin
      hit         <= emit_hit;
      match_index <= emit_idx;
      truncated   <= emit_trunc;
      last        <= emit_last;
    end
  end

  // checks
  `PPM_WMS_ASSERT(a_miss_is_final, clk, rst, result_strobe && !hit |-> last && !truncated)
  `PPM_WMS_ASSERT(a_trunc_is_final_hit, clk, rst, result_strobe && truncated |-> last && hit)
  `PPM_WMS_ASSERT(a_last_ends_query, clk, rst, result_strobe && last |-> state == S_IDLE)
  `PPM_WMS_ASSERT(a_mid_word_in_walk, clk, rst, result_strobe && !last |-> state == S_WALK)
  `PPM_WMS_ASSERT(a_search_bounds, clk, rst, state == S_SEARCH |-> lo <= hi)
  `PPM_WMS_NEVER(a_found_limit, clk, rst, found > CNTW'(MAX_MATCHES))

endmodule

@@ rtl/core/ppm_window_mass_search_unit.sv @@
// ----------------------------------------------------------------------------
// ppm_window_mass_search_unit
// Sorted feature table with a ppm mass window search per query.
//
// Usage:
//   Items enter on start while busy is low. op selects a load (one table
//   slot written at the accepting edge, no result, busy stays low) or a
//   query. A query raises busy until its final result word has gone out.
//   Results appear on hit, match_index, truncated and last for one cycle
//   with result_strobe; the receiver cannot stall them.
//   Order of a query: the accept, then the binary-search probes
//   (ceil(log2(n+1)) probes, 13 for 4096 entries), then one step per
//   entry of the walked run, then the final word. Each probe and
//   walk step is a table read, a difference-times-15625 stage and
//   a compare, all on the single table read port.
//   Each match leaves one word; the last word has last set, and
//   a query with no match yields one miss word.
//   Configuration writes go through cfg_valid/cfg_ready (always ready) and
//   must be done while idle. Reset clears entry_count to 0 and sets the
//   tolerance to 10 ppm; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module ppm_window_mass_search_unit import ppm_wms_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int MAX_MATCHES = DEF_MAX_MATCHES,
  parameter int TIME_MARGIN = DEF_TIME_MARGIN
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [0:0]            op,
  input  logic [INDEX_W-1:0]    entry_index,
  input  logic [MASS_W-1:0]     entry_mass,
  input  logic [CHARGE_W-1:0]   entry_charge,
  input  logic [TIME_W-1:0]     entry_time,
  input  logic [MASS_W-1:0]     query_mass,
  input  logic [CHARGE_W-1:0]   query_charge,
  input  logic [TIME_W-1:0]     window_start,
  input  logic [TIME_W-1:0]     window_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  result_strobe,
  output logic                  hit,
  output logic [INDEX_W-1:0]    match_index,
  output logic                  truncated,
  output logic                  last
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;

  cfg_t              cfg;
  logic              wr_en;
  entry_t            wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  entry_t            rd_data;
  logic              win_load;
  logic [MASS_W-1:0] q_mass;
  logic [LIMH_W-1:0] lim_hi;
  win_flags_t        flags;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.entry_count <= '0;
      cfg.tolerance   <= TOL_W'(TOL_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_ENTRY_COUNT: cfg.entry_count <= COUNT_W'(cfg_data);
        REG_TOLERANCE:   cfg.tolerance   <= TOL_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // table load, slots beyond the depth are dropped
  always_comb begin
    wr_en = start && !busy && (op == OP_LOAD) &&
            (SW'(entry_index) < SW'(TABLE_DEPTH));
    wr_data.mass   = entry_mass;
    wr_data.charge = entry_charge;
    wr_data.rtime  = entry_time;
  end

  ppm_wms_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(entry_index)),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ppm_wms_window u_window (
    .clk        (clk),
    .load       (win_load),
    .mass       (rd_data.mass),
    .query_mass (q_mass),
    .lim_hi     (lim_hi),
    .flags      (flags)
  );

  ppm_wms_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_MATCHES (MAX_MATCHES),
    .TIME_MARGIN (TIME_MARGIN)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .op            (op),
    .query_mass    (query_mass),
    .query_charge  (query_charge),
    .window_start  (window_start),
    .window_end    (window_end),
    .cfg           (cfg),
    .busy          (busy),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .win_load      (win_load),
    .q_mass        (q_mass),
    .lim_hi        (lim_hi),
    .flags         (flags),
    .result_strobe (result_strobe),
    .hit           (hit),
    .match_index   (match_index),
    .truncated     (truncated),
    .last          (last)
  );

endmodule

@@ test/ppm_window_mass_search_unit_tb.sv @@
// ----------------------------------------------------------------------------
// ppm_window_mass_search_unit_tb
// Self-checking bench for the ppm window mass search unit. A directed table
// covers the empty table, the mass and time window edges, zero tolerance,
// a 100 ppm tolerance, count saturation and truncation. Random loads and
// queries then follow under several idle patterns. Every result word is
// compared with a literal word or a local search model of the feature table.
// ----------------------------------------------------------------------------
module ppm_window_mass_search_unit_tb import ppm_wms_pkg::*; ();

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int MAX_MATCHES = DEF_MAX_MATCHES;
  localparam int TIME_MARGIN = DEF_TIME_MARGIN;
  localparam longint unsigned PPM_SCALE_Q8 = 64'd256000000;
  localparam int unsigned MASS_MAX = 32'h3FFF_FFFF;
  localparam int TIME_MAX = 65535;
  localparam int TOL_HIGH = 25600;
  localparam int CLUSTER_BASE = 1000;
  localparam int CLUSTER_SIZE = 80;
  localparam int CLUSTER_TIME = 30000;
  localparam int SETTLE_CYCLES = 16;
  localparam int ITEMS_PER_PHASE = 120;
  // longest quiet stretch: 13 probes plus a 4096 entry walk with no
  // result word; allow about four times that
  localparam int WATCHDOG_LIMIT = 50000;

  typedef enum int {
    ROW_ITEM,
    ROW_CFG,
    ROW_FILL
  } row_kind_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] match_index;
    logic               truncated;
    logic               last;
  } match_word_t;

  typedef struct {
    row_kind_t             kind;
    reg_idx_t              reg_sel;
    logic [CFG_DATA_W-1:0] reg_val;
    int                    aim_slot;
    op_t                   op;
    logic [INDEX_W-1:0]    entry_index;
    logic [MASS_W-1:0]     entry_mass;
    logic [CHARGE_W-1:0]   entry_charge;
    logic [TIME_W-1:0]     entry_time;
    logic [MASS_W-1:0]     query_mass;
    logic [CHARGE_W-1:0]   query_charge;
    logic [TIME_W-1:0]     window_start;
    logic [TIME_W-1:0]     window_end;
    bit                    lit;
    match_word_t           lit_word;
  } stim_row_t;

  // DUT signals
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [0:0]            op = OP_LOAD;
  logic [INDEX_W-1:0]    entry_index = '0;
  logic [MASS_W-1:0]     entry_mass = '0;
  logic [CHARGE_W-1:0]   entry_charge = '0;
  logic [TIME_W-1:0]     entry_time = '0;
  logic [MASS_W-1:0]     query_mass = '0;
  logic [CHARGE_W-1:0]   query_charge = '0;
  logic [TIME_W-1:0]     window_start = '0;
  logic [TIME_W-1:0]     window_end = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  result_strobe;
  logic                  hit;
  logic [INDEX_W-1:0]    match_index;
  logic                  truncated;
  logic                  last;

  // literal expectation travels with the word it belongs to
  logic        lit_valid = 1'b0;
  match_word_t lit_word = '0;

  // search model state
  logic [MASS_W-1:0]   mass_tbl   [TABLE_DEPTH];
  logic [CHARGE_W-1:0] charge_tbl [TABLE_DEPTH];
  logic [TIME_W-1:0]   time_tbl   [TABLE_DEPTH];
  logic [COUNT_W-1:0]  count_reg = '0;
  logic [TOL_W-1:0]    tol_reg = TOL_W'(TOL_RESET);

  match_word_t pending_matches[$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;

  ppm_window_mass_search_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .entry_index(entry_index),
    .entry_mass(entry_mass),
    .entry_charge(entry_charge),
    .entry_time(entry_time),
    .query_mass(query_mass),
    .query_charge(query_charge),
    .window_start(window_start),
    .window_end(window_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_strobe(result_strobe),
    .hit(hit),
    .match_index(match_index),
    .truncated(truncated),
    .last(last)
  );

  // clock, 12 unit period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected words of one query: binary search, then walk the mass run
  function automatic void predict_matches(input logic [MASS_W-1:0] qm,
                                          input logic [CHARGE_W-1:0] qc,
                                          input logic [TIME_W-1:0] ws,
                                          input logic [TIME_W-1:0] we);
    longint unsigned    q, m, lim, n, lo, hi, mid, j, t;
    int                 found, k;
    bit                 cut;
    logic [INDEX_W-1:0] hits [MAX_MATCHES];
    match_word_t        w;
    q = qm;
    lim = q * tol_reg;
    n = count_reg;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    lo = 0;
    hi = n;
    found = 0;
    cut = 1'b0;
    // first entry not below the window
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      m = mass_tbl[mid];
      if (m < q && (q - m) * PPM_SCALE_Q8 > lim) lo = mid + 1;
      else hi = mid;
    end
    // walk until the first entry above the window
    for (j = lo; j < n; j++) begin
      m = mass_tbl[j];
      t = time_tbl[j];
      if (m > q && (m - q) * PPM_SCALE_Q8 > lim) break;
      if (charge_tbl[j] == qc && t + TIME_MARGIN > ws && t < we + TIME_MARGIN) begin
        if (found == MAX_MATCHES) begin
          cut = 1'b1;
          break;
        end
        hits[found] = j[INDEX_W-1:0];
        found++;
      end
    end
    if (found == 0) begin
      w = '0;
      w.last = 1'b1;
      pending_matches.push_back(w);
    end else begin
      for (k = 0; k < found; k++) begin
        w.hit = 1'b1;
        w.match_index = hits[k];
        w.last = (k == found - 1);
        w.truncated = (k == found - 1) && cut;
        pending_matches.push_back(w);
      end
    end
  endfunction

  // track accepted words and register writes
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      if (op == OP_LOAD) begin
        mass_tbl[entry_index] = entry_mass;
        charge_tbl[entry_index] = entry_charge;
        time_tbl[entry_index] = entry_time;
      end else if (lit_valid) begin
        pending_matches.push_back(lit_word);
      end else begin
        predict_matches(query_mass, query_charge, window_start, window_end);
      end
    end
    if (!rst && cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_ENTRY_COUNT: count_reg = cfg_data[COUNT_W-1:0];
        REG_TOLERANCE:   tol_reg = cfg_data[TOL_W-1:0];
      endcase
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk) begin : check_results
    match_word_t want, got;
    if (!rst && result_strobe) begin
      got = {hit, match_index, truncated, last};
      if (pending_matches.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result word hit=%0b index=%0d truncated=%0b last=%0b",
                   $time, got.hit, got.match_index, got.truncated, got.last);
      end else begin
        want = pending_matches.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: result word mismatch: expected hit=%0b index=%0d ",
                      "truncated=%0b last=%0b, got hit=%0b index=%0d truncated=%0b last=%0b"},
                     $time, want.hit, want.match_index, want.truncated, want.last,
                     got.hit, got.match_index, got.truncated, got.last);
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic stim_row_t blank_row();
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.reg_sel = REG_ENTRY_COUNT;
    r.reg_val = '0;
    r.aim_slot = -1;
    r.op = OP_QUERY;
    r.entry_index = '0;
    r.entry_mass = '0;
    r.entry_charge = '0;
    r.entry_time = '0;
    r.query_mass = '0;
    r.query_charge = '0;
    r.window_start = '0;
    r.window_end = '0;
    r.lit = 1'b0;
    r.lit_word = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input reg_idx_t sel, input int val);
    stim_row_t r;
    r = blank_row();
    r.kind = ROW_CFG;
    r.reg_sel = sel;
    r.reg_val = CFG_DATA_W'(val);
    return r;
  endfunction

  function automatic stim_row_t load_row(input int slot, input int unsigned m,
                                         input int c, input int t);
    stim_row_t r;
    r = blank_row();
    r.op = OP_LOAD;
    r.entry_index = INDEX_W'(slot);
    r.entry_mass = MASS_W'(m);
    r.entry_charge = CHARGE_W'(c);
    r.entry_time = TIME_W'(t);
    return r;
  endfunction

  // aim >= 0 takes mass and charge from that table slot at drive time
  function automatic stim_row_t query_row(input int unsigned q, input int c,
                                          input int ws, input int we, input int aim);
    stim_row_t r;
    r = blank_row();
    r.query_mass = MASS_W'(q);
    r.query_charge = CHARGE_W'(c);
    r.window_start = TIME_W'(ws);
    r.window_end = TIME_W'(we);
    r.aim_slot = aim;
    return r;
  endfunction

  // query whose single miss word is known outright
  function automatic stim_row_t miss_row(input int unsigned q, input int c,
                                         input int ws, input int we);
    stim_row_t r;
    r = query_row(q, c, ws, we, -1);
    r.lit = 1'b1;
    r.lit_word.last = 1'b1;
    return r;
  endfunction

  // present one input word after an optional gap, return once it is accepted and busy is low
  task automatic drive_item(input stim_row_t r, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= r.op;
    entry_index <= r.entry_index;
    entry_mass <= r.entry_mass;
    entry_charge <= r.entry_charge;
    entry_time <= r.entry_time;
    query_mass <= r.query_mass;
    query_charge <= r.query_charge;
    window_start <= r.window_start;
    window_end <= r.window_end;
    lit_valid <= r.lit;
    lit_word <= r.lit_word;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // stop sending, let all expected words arrive, then let loads settle
  task automatic wait_until_settled();
    start <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only from idle
  task automatic write_reg(input reg_idx_t sel, input logic [CFG_DATA_W-1:0] val);
    wait_until_settled();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : main_flow
    stim_row_t       directed_rows[$];
    stim_row_t       r;
    int              i, slot, phase, item, gap, roll, idle_pct, eff, tol_val, count_val;
    int              c, t, tlo, thi;
    int unsigned     fill_mass, off;
    longint unsigned lo_m, hi_m, qv, half;

    // directed table
    directed_rows.push_back(miss_row(0, 0, 0, 0));
    directed_rows.push_back(miss_row(MASS_MAX, 15, TIME_MAX, TIME_MAX));
    directed_rows.push_back(cfg_row(REG_TOLERANCE, TOL_HIGH));
    directed_rows.push_back(cfg_row(REG_ENTRY_COUNT, 0));
    directed_rows.push_back(miss_row(123456, 2, 0, TIME_MAX));
    r = blank_row();
    r.kind = ROW_FILL;
    directed_rows.push_back(r);
    directed_rows.push_back(cfg_row(REG_ENTRY_COUNT, TABLE_DEPTH));
    directed_rows.push_back(cfg_row(REG_TOLERANCE, TOL_RESET));
    // zero query mass, no lower time bound
    directed_rows.push_back(query_row(0, 2, 0, TIME_MAX, -1));
    directed_rows.push_back(query_row(0, 0, TIME_MAX, TIME_MAX, TABLE_DEPTH - 1));
    // dense cluster: truncation, then each time edge
    directed_rows.push_back(query_row(0, 0, 29900, 30100, CLUSTER_BASE));
    directed_rows.push_back(query_row(0, 0, 30128, 30000, CLUSTER_BASE));
    directed_rows.push_back(query_row(0, 0, 30127, 29873, CLUSTER_BASE));
    directed_rows.push_back(query_row(0, 0, 29000, 29872, CLUSTER_BASE));
    directed_rows.push_back(cfg_row(REG_TOLERANCE, 0));
    directed_rows.push_back(query_row(0, 0, 0, TIME_MAX, 500));
    directed_rows.push_back(cfg_row(REG_TOLERANCE, TOL_HIGH));
    directed_rows.push_back(query_row(0, 0, 0, TIME_MAX, 2000));
    // count above depth saturates
    directed_rows.push_back(cfg_row(REG_ENTRY_COUNT, 8191));
    directed_rows.push_back(query_row(0, 0, 0, TIME_MAX, TABLE_DEPTH - 1));
    directed_rows.push_back(cfg_row(REG_ENTRY_COUNT, 1));
    directed_rows.push_back(query_row(0, 0, 0, TIME_MAX, 0));
    directed_rows.push_back(load_row(0, 0, 0, 0));
    directed_rows.push_back(load_row(TABLE_DEPTH - 1, MASS_MAX, 15, TIME_MAX));
    directed_rows.push_back(cfg_row(REG_ENTRY_COUNT, TABLE_DEPTH));
    directed_rows.push_back(query_row(MASS_MAX, 15, TIME_MAX, TIME_MAX, -1));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    for (i = 0; i < directed_rows.size(); i++) begin
      r = directed_rows[i];
      case (r.kind)
        ROW_CFG: write_reg(r.reg_sel, r.reg_val);
        ROW_FILL: begin
          // sorted table: small steps with rare jumps, one dense cluster
          fill_mass = 0;
          for (slot = 0; slot < TABLE_DEPTH; slot++) begin
            if (slot == 0) begin
              fill_mass = 0;
              c = 2;
              t = 0;
            end else if (slot == TABLE_DEPTH - 1) begin
              fill_mass = MASS_MAX;
              c = 15;
              t = TIME_MAX;
            end else if (slot >= CLUSTER_BASE && slot < CLUSTER_BASE + CLUSTER_SIZE) begin
              c = 3;
              t = CLUSTER_TIME;
            end else begin
              if ($urandom_range(0, 7) == 0) off = $urandom_range(0, 2000000);
              else off = $urandom_range(0, 400);
              if (fill_mass + off > MASS_MAX - 1) fill_mass = MASS_MAX - 1;
              else fill_mass = fill_mass + off;
              c = ($urandom_range(0, 3) != 0) ? int'($urandom_range(1, 4))
                                              : int'($urandom_range(0, 15));
              t = slot * 15 + int'($urandom_range(0, 600));
            end
            drive_item(load_row(slot, fill_mass, c, t), 0);
          end
        end
        default: begin
          if (r.aim_slot >= 0) begin
            r.query_mass = mass_tbl[r.aim_slot];
            r.query_charge = charge_tbl[r.aim_slot];
          end
          drive_item(r, 0);
        end
      endcase
    end

    // random part in four idle phases
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          tol_val = TOL_RESET;
          count_val = TABLE_DEPTH;
        end
        1: begin
          idle_pct = 69;
          tol_val = TOL_HIGH;
          count_val = $urandom_range(1, TABLE_DEPTH);
        end
        2: begin
          idle_pct = 0;
          tol_val = $urandom_range(0, TOL_HIGH);
          count_val = TABLE_DEPTH;
        end
        default: begin
          idle_pct = 16;
          tol_val = $urandom_range(0, TOL_HIGH);
          count_val = $urandom_range(TABLE_DEPTH + 1, 8191);
        end
      endcase
      write_reg(REG_TOLERANCE, CFG_DATA_W'(tol_val));
      write_reg(REG_ENTRY_COUNT, CFG_DATA_W'(count_val));
      eff = (count_val > TABLE_DEPTH) ? TABLE_DEPTH : count_val;

      for (item = 0; item < ITEMS_PER_PHASE; item++) begin
        // unused fields carry random values too
        r = blank_row();
        r.entry_index = INDEX_W'($urandom_range(0, TABLE_DEPTH - 1));
        r.entry_mass = MASS_W'($urandom_range(0, MASS_MAX));
        r.entry_charge = CHARGE_W'($urandom_range(0, 15));
        r.entry_time = TIME_W'($urandom_range(0, TIME_MAX));
        r.query_mass = MASS_W'($urandom_range(0, MASS_MAX));
        r.query_charge = CHARGE_W'($urandom_range(0, 15));
        r.window_start = TIME_W'($urandom_range(0, TIME_MAX));
        r.window_end = TIME_W'($urandom_range(0, TIME_MAX));
        roll = $urandom_range(0, 99);
        if (roll < 25) begin
          // load: mostly keeps the order, a few break it
          r.op = OP_LOAD;
          slot = r.entry_index;
          if (roll >= 3) begin
            lo_m = (slot == 0) ? 64'd0 : 64'(mass_tbl[slot - 1]);
            hi_m = (slot == TABLE_DEPTH - 1) ? 64'(MASS_MAX) : 64'(mass_tbl[slot + 1]);
            if (lo_m < hi_m)
              lo_m = lo_m + ({$urandom, $urandom} % (hi_m - lo_m + 1));
            r.entry_mass = lo_m[MASS_W-1:0];
          end
        end else if (roll < 92) begin
          // well-formed query around a table entry
          slot = $urandom_range(0, eff - 1);
          if (roll < 30 && eff > CLUSTER_BASE + CLUSTER_SIZE)
            slot = CLUSTER_BASE + int'($urandom_range(0, CLUSTER_SIZE - 1));
          qv = mass_tbl[slot];
          half = (qv * tol_val) / PPM_SCALE_Q8 + 2;
          off = $urandom_range(0, 2 * int'(half));
          qv = qv + off;
          qv = (qv < half) ? 64'd0 : qv - half;
          if (qv > MASS_MAX) qv = MASS_MAX;
          r.query_mass = qv[MASS_W-1:0];
          if (roll < 88) r.query_charge = charge_tbl[slot];
          t = time_tbl[slot];
          tlo = t - int'($urandom_range(0, 400));
          thi = t - 200 + int'($urandom_range(0, 600));
          if (tlo < 0) tlo = 0;
          if (thi < 0) thi = 0;
          if (thi > TIME_MAX) thi = TIME_MAX;
          r.window_start = TIME_W'(tlo);
          r.window_end = TIME_W'(thi);
        end
        gap = 0;
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct && gap < 50) gap++;
        drive_item(r, gap);
        // hold off once mid-phase until every match word is back
        if (phase == 1 && item == ITEMS_PER_PHASE / 2) wait_until_settled();
      end
    end

    wait_until_settled();
    if (mismatch_count == 0 && pending_matches.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ppm_wms_pkg.sv
rtl/core/ppm_wms_table.sv
rtl/core/ppm_wms_window.sv
rtl/core/ppm_wms_seq.sv
rtl/core/ppm_window_mass_search_unit.sv
test/ppm_window_mass_search_unit_tb.sv
